[hdl/display_return_frame_parser_defines.svh]
// Assertion macros shared by the frame parser RTL.
`ifndef DISPLAY_RETURN_FRAME_PARSER_DEFINES_SVH
`define DISPLAY_RETURN_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define DRFP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DRFP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/drfp_pkg.sv]
// Shared constants, codes and types of the display return frame parser.
`default_nettype none

package drfp_pkg;

  localparam int FRAME_DEPTH    = 64;
  localparam int MAX_COMPONENTS = 8;
  localparam int RESULT_CAP     = 60;

  localparam int ADDR_W  = $clog2(FRAME_DEPTH);
  localparam int POS_W   = $clog2(FRAME_DEPTH + 1);
  // wide enough for a store index and for the text cap
  localparam int IDX_W   = (ADDR_W > 6) ? ADDR_W + 1 : 7;
  localparam int COMP_W  = 3;
  localparam int CNT_W   = 4;
  localparam int RIDX_W  = 3;
  localparam int CFG_W   = 64;
  localparam int KIND_W  = 3;
  localparam int TLEN_W  = 6;
  localparam int WORD_W  = 32;

  localparam logic [7:0] TERM_BYTE = 8'hFF;

  localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd4;

  localparam logic [RIDX_W-1:0] REG_COMPONENT_COUNT = 3'd0;
  localparam logic [RIDX_W-1:0] REG_KEYS_LOW        = 3'd1;
  localparam logic [RIDX_W-1:0] REG_KEYS_HIGH       = 3'd2;
  localparam logic [RIDX_W-1:0] REG_PRESS_MASK      = 3'd3;
  localparam logic [RIDX_W-1:0] REG_RELEASE_MASK    = 3'd4;
  localparam logic [RIDX_W-1:0] REG_TOUCH_HEADER    = 3'd5;
  localparam logic [RIDX_W-1:0] REG_STRING_HEADER   = 3'd6;
  localparam logic [RIDX_W-1:0] REG_NUMBER_HEADER   = 3'd7;

  localparam logic [7:0] TOUCH_HEADER_RST  = 8'd101;
  localparam logic [7:0] STRING_HEADER_RST = 8'd112;
  localparam logic [7:0] NUMBER_HEADER_RST = 8'd113;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COMP_W-1:0] component_index;
    logic [WORD_W-1:0] payload;
    logic [TLEN_W-1:0] text_length;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[hdl/drfp_frame_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drfp_frame_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/display_return_frame_parser.sv]
// Top level: byte capture into the frame store and frame-end decode sequencer.
//
//  channel  | handshake                 | contents
//  ---------+---------------------------+---------------------------------------------
//  rx       | rx_valid / rx_ready       | rx_byte
//  result   | res_valid / res_ready     | kind, component_index, payload, text_length, last
//  config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// A byte that does not close a frame leaves the parser idle, so rx_ready stays high.
// A closing byte starts the header reads, then on a touch frame the walk over the table
// entries, on a string frame the scan for the third terminator, the text start and a read
// and an emit per text byte, then the number step and the flush; a stalled result port
// adds its wait to each word. After reset a clearing pass zeroes the store, rx_ready held low.
// The last result word waits in the output register while the next byte is taken.
`default_nettype none
`include "display_return_frame_parser_defines.svh"

module display_return_frame_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rx_valid,
  output logic                                rx_ready,
  input  wire logic [7:0]                     rx_byte,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic [drfp_pkg::KIND_W-1:0]         kind,
  output logic [drfp_pkg::COMP_W-1:0]         component_index,
  output logic [drfp_pkg::WORD_W-1:0]         payload,
  output logic [drfp_pkg::TLEN_W-1:0]         text_length,
  output logic                                last,
  input  wire logic                           cfg_we,
  input  wire logic [drfp_pkg::RIDX_W-1:0]    cfg_index,
  input  wire logic [drfp_pkg::CFG_W-1:0]     cfg_data
);

  import drfp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_TOUCH, S_SCAN, S_TXT, S_TXT_RD, S_TXT_EM, S_NUM, S_FLUSH
  } state_t;

  state_t state;

  // configuration
  logic [CNT_W-1:0]  comp_count;
  logic [CFG_W-1:0]  keys_low;
  logic [CFG_W-1:0]  keys_high;
  logic [7:0]        press_mask;
  logic [7:0]        release_mask;
  logic [7:0]        touch_hdr;
  logic [7:0]        string_hdr;
  logic [7:0]        number_hdr;

  // frame tracking
  logic [POS_W-1:0]  pos;
  logic [1:0]        run;
  logic [1:0]        run_next;
  logic [ADDR_W-1:0] clr_addr;

  // decode
  logic [2:0]        ld;
  logic [7:0]        fb [0:4];
  logic [CNT_W-1:0]  comp;
  logic [CNT_W-1:0]  cnt_eff;
  logic [POS_W-1:0]  scan_addr;
  logic              chk_vld;
  logic [ADDR_W-1:0] chk_idx;
  logic [1:0]        ffs;
  logic [TLEN_W-1:0] txt_len;
  logic [TLEN_W-1:0] txt_k;
  logic [IDX_W-1:0]  txt_addr_w;
  logic [IDX_W-1:0]  idx_w;
  logic [IDX_W-1:0]  len_w;
  logic [TLEN_W-1:0] len_clip;
  logic [5:0]        n;

  // result path
  result_t           res;
  result_t           res_next;
  logic              res_load;
  result_t           pend;
  logic              pend_valid;
  result_t           emit_res;
  logic              emit_req;
  logic              emit_take;
  logic              emit_done;
  logic              can_move;

  // store access
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        mem_q;

  logic              accept;
  logic [15:0]       key;
  logic [CFG_W-1:0]  key_word;
  logic              key_hit;

  drfp_frame_ram #(
    .DEPTH (FRAME_DEPTH),
    .WIDTH (8)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  assign rx_ready = (state == S_IDLE);
  assign accept   = rx_valid && rx_ready;
  assign run_next = (rx_byte == TERM_BYTE) ? run + 2'd1 : 2'd0;

  assign ram_we    = (state == S_CLEAR) || (accept && (pos < POS_W'(FRAME_DEPTH)));
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : pos[ADDR_W-1:0];
  assign ram_wdata = (state == S_CLEAR) ? 8'h00 : rx_byte;

  assign cnt_eff  = (comp_count > CNT_W'(MAX_COMPONENTS)) ? CNT_W'(MAX_COMPONENTS) : comp_count;
  assign key_word = comp[2] ? keys_high : keys_low;
  assign key      = key_word[{comp[1:0], 4'b0000} +: 16];
  assign key_hit  = (fb[1] == key[15:8]) && (fb[2] == key[7:0]);

  assign txt_addr_w = IDX_W'(txt_k) + IDX_W'(1);

  // text length from the position of the third terminator
  assign idx_w    = IDX_W'(chk_idx);
  assign len_w    = (idx_w > IDX_W'(3)) ? idx_w - IDX_W'(3) : '0;
  assign len_clip = (len_w > IDX_W'(RESULT_CAP)) ? TLEN_W'(RESULT_CAP) : len_w[TLEN_W-1:0];

  always_comb begin
    case (state)
      S_LOAD:             rd_addr = ADDR_W'(ld);
      S_SCAN:             rd_addr = scan_addr[ADDR_W-1:0];
      S_TXT_RD, S_TXT_EM: rd_addr = txt_addr_w[ADDR_W-1:0];
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    case (state)
      S_TOUCH: begin
        if ((fb[0] == touch_hdr) && (comp < cnt_eff) && key_hit) begin
          if ((fb[3] == 8'd1) && press_mask[comp[COMP_W-1:0]]) begin
            emit_req                 = 1'b1;
            emit_res.kind            = KIND_PRESS;
            emit_res.component_index = comp[COMP_W-1:0];
          end else if ((fb[3] == 8'd0) && release_mask[comp[COMP_W-1:0]]) begin
            emit_req                 = 1'b1;
            emit_res.kind            = KIND_RELEASE;
            emit_res.component_index = comp[COMP_W-1:0];
          end
        end
      end
      S_TXT: begin
        if (txt_len == '0) begin
          emit_req      = 1'b1;
          emit_res.kind = KIND_EMPTY;
        end
      end
      S_TXT_EM: begin
        emit_req             = 1'b1;
        emit_res.kind        = KIND_TEXT;
        emit_res.payload     = {24'd0, mem_q};
        emit_res.text_length = txt_len;
      end
      S_NUM: begin
        if (fb[0] == number_hdr) begin
          emit_req         = 1'b1;
          emit_res.kind    = KIND_NUMBER;
          emit_res.payload = {fb[4], fb[3], fb[2], fb[1]};
        end
      end
      default: ;
    endcase
  end

  // one result is held back so the final word of a frame can carry last
  assign can_move  = !res_valid || res_ready;
  assign emit_take = emit_req && (n < 6'(RESULT_CAP)) && (!pend_valid || can_move);
  assign emit_done = !emit_req || emit_take || (n >= 6'(RESULT_CAP));
  assign res_load  = pend_valid && (emit_take || ((state == S_FLUSH) && can_move));

  always_comb begin
    res_next      = pend;
    res_next.last = (state == S_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pos          <= '0;
      run          <= '0;
      res_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      comp_count   <= '0;
      keys_low     <= '0;
      keys_high    <= '0;
      press_mask   <= '0;
      release_mask <= '0;
      touch_hdr    <= TOUCH_HEADER_RST;
      string_hdr   <= STRING_HEADER_RST;
      number_hdr   <= NUMBER_HEADER_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMPONENT_COUNT: comp_count   <= cfg_data[CNT_W-1:0];
          REG_KEYS_LOW:        keys_low     <= cfg_data;
          REG_KEYS_HIGH:       keys_high    <= cfg_data;
          REG_PRESS_MASK:      press_mask   <= cfg_data[7:0];
          REG_RELEASE_MASK:    release_mask <= cfg_data[7:0];
          REG_TOUCH_HEADER:    touch_hdr    <= cfg_data[7:0];
          REG_STRING_HEADER:   string_hdr   <= cfg_data[7:0];
          REG_NUMBER_HEADER:   number_hdr   <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (res_load) begin
        res       <= res_next;
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (emit_take) begin
        pend       <= emit_res;
        pend_valid <= 1'b1;
        n          <= n + 6'd1;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(FRAME_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (run_next == 2'd3) begin
              pos   <= '0;
              run   <= '0;
              ld    <= '0;
              n     <= '0;
              state <= S_LOAD;
            end else begin
              if (pos < POS_W'(FRAME_DEPTH)) begin
                pos <= pos + POS_W'(1);
              end
              run <= run_next;
            end
          end
        end
        S_LOAD: begin
          if (ld != 3'd0) begin
            fb[ld - 3'd1] <= mem_q;
          end
          ld <= ld + 3'd1;
          if (ld == 3'd5) begin
            comp      <= '0;
            scan_addr <= '0;
            chk_vld   <= 1'b0;
            ffs       <= '0;
            state     <= S_TOUCH;
          end
        end
        S_TOUCH: begin
          if ((fb[0] != touch_hdr) || (comp >= cnt_eff)) begin
            state <= (fb[0] == string_hdr) ? S_SCAN : S_NUM;
          end else if (emit_done) begin
            comp <= comp + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (scan_addr < POS_W'(FRAME_DEPTH)) begin
            chk_vld   <= 1'b1;
            chk_idx   <= scan_addr[ADDR_W-1:0];
            scan_addr <= scan_addr + POS_W'(1);
          end else begin
            chk_vld <= 1'b0;
          end
          if (chk_vld) begin
            if ((mem_q == TERM_BYTE) && (ffs == 2'd2)) begin
              txt_len <= len_clip;
              txt_k   <= '0;
              state   <= S_TXT;
            end else begin
              if (mem_q == TERM_BYTE) begin
                ffs <= ffs + 2'd1;
              end
              // no third terminator anywhere: empty text
              if (chk_idx == ADDR_W'(FRAME_DEPTH - 1)) begin
                txt_len <= '0;
                txt_k   <= '0;
                state   <= S_TXT;
              end
            end
          end
        end
        S_TXT: begin
          if (txt_len != '0) begin
            state <= S_TXT_RD;
          end else if (emit_done) begin
            state <= S_NUM;
          end
        end
        S_TXT_RD: begin
          state <= S_TXT_EM;
        end
        S_TXT_EM: begin
          if (emit_done) begin
            if (txt_k == txt_len - TLEN_W'(1)) begin
              state <= S_NUM;
            end else begin
              txt_k <= txt_k + TLEN_W'(1);
              state <= S_TXT_RD;
            end
          end
        end
        S_NUM: begin
          if (emit_done) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (can_move) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind            = res.kind;
  assign component_index = res.component_index;
  assign payload         = res.payload;
  assign text_length     = res.text_length;
  assign last            = res.last;

  `DRFP_ASSERT_IMP(a_accept_no_pending, clk, rst, rx_valid && rx_ready, !pend_valid, "byte taken while a result is held back")
  `DRFP_ASSERT_NEXT(a_frame_end_decode, clk, rst, accept && (run_next == 2'd3), (state == S_LOAD) && (pos == '0), "frame end did not start decode")
  `DRFP_ASSERT_NEXT(a_flush_marks_last, clk, rst, (state == S_FLUSH) && pend_valid && can_move, res_valid && last, "final word not marked last")

endmodule

`default_nettype wire
